[hdl/etg_pkg.sv]
// shared constants and codes for the eased tween generator
`timescale 1ns / 1ps

package etg_pkg;

	// default sizes handed to the top level parameters
	localparam int EASE_FRAC_BITS_DEF = 16;
	localparam int VALUE_WIDTH_DEF    = 24;

	// fixed field widths
	localparam int OP_W      = 3;
	localparam int DELTA_W   = 16;
	localparam int DUR_W     = 24;
	localparam int CURVE_W   = 3;
	localparam int ELAPSED_W = 25;
	localparam int CFG_IDX_W = 2;

	// operation codes
	localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
	localparam logic [OP_W-1:0] OP_START  = 3'd1;
	localparam logic [OP_W-1:0] OP_STOP   = 3'd2;
	localparam logic [OP_W-1:0] OP_PAUSE  = 3'd3;
	localparam logic [OP_W-1:0] OP_RESUME = 3'd4;

	// easing curve codes, anything else runs linear
	localparam logic [CURVE_W-1:0] CRV_LINEAR   = 3'd0;
	localparam logic [CURVE_W-1:0] CRV_EASE_IN  = 3'd1;
	localparam logic [CURVE_W-1:0] CRV_EASE_OUT = 3'd2;
	localparam logic [CURVE_W-1:0] CRV_IN_OUT   = 3'd3;
	localparam logic [CURVE_W-1:0] CRV_BOUNCE   = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_VALUE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_VALUE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DURATION    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EASING      = 2'd3;

	// reset value of the duration register
	localparam logic [DUR_W-1:0] DUR_RESET = 24'd1;

endpackage

[hdl/etg_div.sv]
// bit-serial restoring divider for the progress fraction
`timescale 1ns / 1ps

module etg_div #(
	parameter int FRAC_BITS = etg_pkg::EASE_FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [etg_pkg::DUR_W-1:0]  num,   // must be below den
	input  logic [etg_pkg::DUR_W-1:0]  den,
	output logic [FRAC_BITS-1:0]       quot,
	output logic                       done
);

	localparam int DW    = etg_pkg::DUR_W;
	localparam int CNT_W = $clog2(FRAC_BITS);

	logic [DW-1:0]        rem_q;
	logic [DW-1:0]        den_q;
	logic [FRAC_BITS-1:0] quot_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DW:0] rem2;
	logic [DW:0] trial;
	logic        fits;

	// one quotient bit per cycle
	assign rem2  = {rem_q, 1'b0};
	assign trial = rem2 - {1'b0, den_q};
	assign fits  = (rem2 >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(FRAC_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? trial[DW-1:0] : rem2[DW-1:0];
			quot_q <= {quot_q[FRAC_BITS-2:0], fits};
		end
	end

	assign quot = quot_q;
	assign done = done_q;

endmodule

[hdl/etg_mul.sv]
// bit-serial shift-add multiplier, signed multiplicand by unsigned multiplier
`timescale 1ns / 1ps

module etg_mul #(
	parameter int AW = 25,
	parameter int BW = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [AW-1:0] a,
	input  logic [BW-1:0]        b,
	output logic signed [AW+BW:0] prod,
	output logic                 done
);

	localparam int CNT_W = $clog2(BW);

	logic signed [AW-1:0] a_q;
	logic signed [AW:0]   hi_q;
	logic [BW-1:0]        lo_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic signed [AW:0] sum;

	// add the multiplicand when the low multiplier bit is set, then shift right
	assign sum = hi_q + (lo_q[0] ? (AW+1)'(a_q) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(BW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= {sum[AW], sum[AW:1]};
			lo_q <= {sum[0], lo_q[BW-1:1]};
		end
	end

	assign prod = {hi_q, lo_q};
	assign done = done_q;

endmodule

[hdl/eased_tween_generator.sv]
// top level of the eased tween generator: op decode, flags, easing sequencer
`timescale 1ns / 1ps

// channel   dir  signals                            contents
// s_        in   s_tvalid s_tready s_tdata s_tuser  s_tuser operation, s_tdata delta_time
// m_        out  m_tvalid m_tready m_tdata m_tlast  m_tdata eased_value, m_tlast done_res
// cfg_      in   cfg_we cfg_index cfg_data          register write, no read-back
//
// a tick that lands before the end runs in order:
// one serial divide (one quotient bit a cycle), then a square and the final
// scale on one shared bit-serial multiplier;
// a final tick skips the divide, linear skips the square
// start emits the start value, stop/pause/resume and ignored ticks emit nothing
// one item at a time; s_tready is low while an item is in flight
// a finished result sits in the output register, a stalled m_tready holds it
// reset clears flags, elapsed time and registers to their reset values

module eased_tween_generator #(
	parameter int EASE_FRAC_BITS = etg_pkg::EASE_FRAC_BITS_DEF,
	parameter int VALUE_WIDTH    = etg_pkg::VALUE_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [etg_pkg::DELTA_W-1:0]   s_tdata,   // [15:0] delta_time
	input  logic [etg_pkg::OP_W-1:0]      s_tuser,   // [2:0] operation

	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [((VALUE_WIDTH+7)/8)*8-1:0] m_tdata, // [VALUE_WIDTH-1:0] eased_value
	output logic                          m_tlast,   // done_res, last result of a run

	input  logic                          cfg_we,
	input  logic [etg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [((VALUE_WIDTH > etg_pkg::DUR_W) ? VALUE_WIDTH : etg_pkg::DUR_W)-1:0] cfg_data
);

	localparam int F     = EASE_FRAC_BITS;
	localparam int VW    = VALUE_WIDTH;
	localparam int EW    = F + 1;                          // eased/progress width, holds 1.0
	localparam int BW    = F + 4;                          // square operand width
	localparam int AW    = (VW + 1 > F + 5) ? VW + 1 : F + 5;
	localparam int PW    = AW + BW + 1;
	localparam int OUT_W = ((VW + 7) / 8) * 8;
	localparam int XW    = EW + 5;                         // bounce working width
	localparam int ELW   = etg_pkg::ELAPSED_W;
	localparam int DW    = etg_pkg::DUR_W;

	localparam logic [EW-1:0] ONE   = EW'(1) << F;
	localparam logic [EW-1:0] HALF  = EW'(1) << (F - 1);
	localparam logic [EW-1:0] C_B1  = EW'((3 << F) >> 2);
	localparam logic [EW-1:0] C_B2  = EW'((15 << F) >> 4);
	localparam logic [EW-1:0] C_B3  = EW'((63 << F) >> 6);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_PREP,
		ST_SQR,
		ST_SCL_GO,
		ST_SCALE,
		ST_EMIT
	} state_t;

	// configuration registers
	logic [VW-1:0]                    start_q;
	logic [VW-1:0]                    end_q;
	logic [DW-1:0]                    dur_q;
	logic [etg_pkg::CURVE_W-1:0]      curve_q;

	// animation state and datapath registers
	state_t         state_q;
	logic [ELW-1:0] elapsed_q;
	logic           running_q;
	logic           paused_q;
	logic           completed_q;
	logic [EW-1:0]  t_q;
	logic [EW-1:0]  e_q;
	logic [VW-1:0]  val_q;
	logic           done_q;
	logic           m_tvalid_q;
	logic [VW-1:0]  out_val_q;
	logic           out_done_q;

	logic            accept;
	logic [DW-1:0]   dur_eff;
	logic [ELW:0]    elapsed_sum;
	logic [ELW-1:0]  elapsed_sat;
	logic            reach_end;
	logic            tick_live;
	logic            div_start;
	logic [F-1:0]    div_quot;
	logic            div_done;

	logic [XW-1:0]        t11;
	logic signed [XW-1:0] bnc_u;
	logic [XW-1:0]        bnc_abs;
	logic [1:0]           bnc_seg;
	logic [BW-1:0]        sq_op;
	logic                 use_sq;
	logic [2*BW-1:0]      sq;
	logic [EW-1:0]        ease_sq;

	logic signed [VW:0]   diff;
	logic signed [AW-1:0] mul_a;
	logic [BW-1:0]        mul_b;
	logic                 mul_start;
	logic signed [PW-1:0] mul_prod;
	logic                 mul_done;
	logic signed [PW-1:0] scaled;

	// config writes, to be made only while the block is idle; the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q   <= '0;
			dur_q   <= etg_pkg::DUR_RESET;
			curve_q <= etg_pkg::CRV_LINEAR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				etg_pkg::REG_START_VALUE: start_q <= cfg_data[VW-1:0];
				etg_pkg::REG_END_VALUE:   end_q   <= cfg_data[VW-1:0];
				etg_pkg::REG_DURATION:    dur_q   <= cfg_data[DW-1:0];
				etg_pkg::REG_EASING:      curve_q <= cfg_data[etg_pkg::CURVE_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// zero duration behaves as one time unit
	assign dur_eff = (dur_q == '0) ? DW'(1) : dur_q;

	// elapsed time saturates at its full-scale value
	assign elapsed_sum = {1'b0, elapsed_q} + (ELW+1)'(s_tdata);
	assign elapsed_sat = elapsed_sum[ELW] ? {ELW{1'b1}} : elapsed_sum[ELW-1:0];
	assign reach_end   = (elapsed_sat >= ELW'(dur_eff));
	assign tick_live   = running_q && !paused_q && !completed_q;

	assign div_start = accept && (s_tuser == etg_pkg::OP_TICK) && tick_live && !reach_end;

	// fraction of the run, elapsed is below duration here
	etg_div #(
		.FRAC_BITS (F)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (elapsed_sat[DW-1:0]),
		.den    (dur_eff),
		.quot   (div_quot),
		.done   (div_done)
	);

	// bounce segments break where 11*t crosses 4, 8 and 10
	assign t11 = (XW'(t_q) << 3) + (XW'(t_q) << 1) + XW'(t_q);

	always_comb begin
		if (t11 < (XW'(4) << F)) begin
			bnc_seg = 2'd0;
		end else if (t11 < (XW'(8) << F)) begin
			bnc_seg = 2'd1;
		end else if (t11 < (XW'(10) << F)) begin
			bnc_seg = 2'd2;
		end else begin
			bnc_seg = 2'd3;
		end
	end

	// u = 22*t - k*ONE, k picked by segment
	always_comb begin
		case (bnc_seg)
			2'd0:    bnc_u = $signed(t11 << 1);
			2'd1:    bnc_u = $signed((t11 << 1) - (XW'(12) << F));
			2'd2:    bnc_u = $signed((t11 << 1) - (XW'(18) << F));
			default: bnc_u = $signed((t11 << 1) - (XW'(21) << F));
		endcase
		bnc_abs = (bnc_u < 0) ? XW'(-bnc_u) : XW'(bnc_u);
	end

	// operand to square, and whether the curve squares at all
	always_comb begin
		use_sq = 1'b1;
		case (curve_q) inside
			etg_pkg::CRV_EASE_IN:  sq_op = BW'(t_q);
			etg_pkg::CRV_EASE_OUT: sq_op = BW'(ONE - t_q);
			etg_pkg::CRV_IN_OUT:   sq_op = (t_q < HALF) ? BW'(t_q) : (BW'(ONE - t_q) << 1);
			etg_pkg::CRV_BOUNCE:   sq_op = bnc_abs[BW-1:0];
			default: begin
				sq_op  = BW'(t_q);
				use_sq = 1'b0;
			end
		endcase
	end

	// shape the square into the eased fraction
	assign sq = mul_prod[2*BW-1:0];

	always_comb begin
		case (curve_q) inside
			etg_pkg::CRV_EASE_IN:  ease_sq = EW'(sq >> F);
			etg_pkg::CRV_EASE_OUT: ease_sq = ONE - EW'(sq >> F);
			etg_pkg::CRV_IN_OUT:
				ease_sq = (t_q < HALF) ? EW'(sq >> (F - 1)) : ONE - EW'(sq >> (F + 1));
			etg_pkg::CRV_BOUNCE: begin
				case (bnc_seg)
					2'd0:    ease_sq = EW'(sq >> (F + 6));
					2'd1:    ease_sq = EW'(sq >> (F + 6)) + C_B1;
					2'd2:    ease_sq = EW'(sq >> (F + 6)) + C_B2;
					default: ease_sq = EW'(sq >> (F + 6)) + C_B3;
				endcase
			end
			default: ease_sq = t_q;
		endcase
	end

	// shared multiplier: square first, then (end - start) * eased
	assign diff      = $signed({end_q[VW-1], end_q}) - $signed({start_q[VW-1], start_q});
	assign mul_start = ((state_q == ST_PREP) && use_sq) || (state_q == ST_SCL_GO);
	assign mul_a     = (state_q == ST_SCL_GO) ? AW'(diff) : $signed(AW'(sq_op));
	assign mul_b     = (state_q == ST_SCL_GO) ? BW'(e_q) : sq_op;

	etg_mul #(
		.AW (AW),
		.BW (BW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (mul_prod),
		.done   (mul_done)
	);

	// floor shift back to value scale
	assign scaled = mul_prod >>> F;

	// sequencer, flags and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			elapsed_q   <= '0;
			running_q   <= 1'b0;
			paused_q    <= 1'b0;
			completed_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
			done_q      <= 1'b0;
			t_q         <= '0;
			e_q         <= '0;
			val_q       <= '0;
			out_val_q   <= '0;
			out_done_q  <= 1'b0;
		end else begin
			// the emit step reloads the output register itself
			if (m_tvalid_q && m_tready && (state_q != ST_EMIT)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (s_tuser) inside
							etg_pkg::OP_TICK: begin
								if (tick_live) begin
									elapsed_q <= elapsed_sat;
									done_q    <= reach_end;
									if (reach_end) begin
										completed_q <= 1'b1;
										running_q   <= 1'b0;
										t_q         <= ONE;
										state_q     <= ST_PREP;
									end else begin
										state_q <= ST_DIV;
									end
								end
							end
							etg_pkg::OP_START: begin
								running_q   <= 1'b1;
								elapsed_q   <= '0;
								completed_q <= 1'b0;
								paused_q    <= 1'b0;
								val_q       <= start_q;
								done_q      <= 1'b0;
								state_q     <= ST_EMIT;
							end
							etg_pkg::OP_STOP:   running_q <= 1'b0;
							etg_pkg::OP_PAUSE:  paused_q  <= 1'b1;
							etg_pkg::OP_RESUME: paused_q  <= 1'b0;
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					if (div_done) begin
						t_q     <= EW'(div_quot);
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (use_sq) begin
						state_q <= ST_SQR;
					end else begin
						e_q     <= t_q;
						state_q <= ST_SCL_GO;
					end
				end
				ST_SQR: begin
					if (mul_done) begin
						e_q     <= ease_sq;
						state_q <= ST_SCL_GO;
					end
				end
				ST_SCL_GO: state_q <= ST_SCALE;
				ST_SCALE: begin
					if (mul_done) begin
						val_q   <= start_q + scaled[VW-1:0];
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// wait for the output register to free up
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						out_val_q  <= val_q;
						out_done_q <= done_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'(out_val_q);
	assign m_tlast  = out_done_q;

`ifndef SYNTHESIS
	// a finished run is never still running
	assert property (@(posedge clk) disable iff (!arst_n) !(running_q && completed_q))
		else $error("running and completed set together");

	// divider results only arrive while the sequencer waits for them
	assert property (@(posedge clk) disable iff (!arst_n) div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide step");

	// multiplier results only arrive in the square or scale step
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_SQR || state_q == ST_SCALE))
		else $error("multiplier finished outside a multiply step");

	// a transfer that completes the run leaves the flags in the completed state
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && done_q) |-> (completed_q && !running_q))
		else $error("completing result without completed flag");
`endif

endmodule

[verif/tween_checker.sv]
// result checker for the eased tween generator: tracks tween state, predicts and compares
`timescale 1ns / 1ps

module tween_checker
	import etg_pkg::*;
#(
	parameter int EASE_FRAC_BITS = EASE_FRAC_BITS_DEF,
	parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	input  logic                                   s_tready,
	input  logic [DELTA_W-1:0]                     s_tdata,
	input  logic [OP_W-1:0]                        s_tuser,
	input  logic                                   m_tvalid,
	input  logic                                   m_tready,
	input  logic [((VALUE_WIDTH+7)/8)*8-1:0]       m_tdata,
	input  logic                                   m_tlast,
	input  logic                                   cfg_we,
	input  logic [CFG_IDX_W-1:0]                   cfg_index,
	input  logic [((VALUE_WIDTH > DUR_W) ? VALUE_WIDTH : DUR_W)-1:0] cfg_data,
	output int                                     fail_count,
	output int                                     pending_count
);

	localparam int F = EASE_FRAC_BITS;
	localparam longint unsigned ONE = 64'd1 << F;
	localparam longint unsigned ELAPSED_MAX = (64'd1 << ELAPSED_W) - 64'd1;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] value;
		logic                   done;
	} tween_point_t;

	tween_point_t due_q[$];
	tween_point_t fresh, head;

	// own copy of the registers and the tween state
	longint            start_val, end_val;
	logic [DUR_W-1:0]  dur_reg;
	logic [CURVE_W-1:0] curve_reg;
	longint unsigned   elapsed;
	logic              running, paused, completed;

	// easing curve applied to progress t, both with F fraction bits
	function automatic longint unsigned shape(input longint unsigned t);
		longint unsigned r, a, c;
		longint          u, k;
		case (curve_reg)
		CRV_EASE_IN: return (t * t) >> F;
		CRV_EASE_OUT: begin
			r = ONE - t;
			return ONE - ((r * r) >> F);
		end
		CRV_IN_OUT: begin
			if (t < ONE / 2)
				return (2 * t * t) >> F;
			r = 2 * ONE - 2 * t;
			return ONE - ((r * r) >> (F + 1));
		end
		CRV_BOUNCE: begin
			// parabola pieces split where 11*t crosses 4, 8 and 10
			if (11 * t < 4 * ONE) begin
				k = 0;
				c = 0;
			end else if (11 * t < 8 * ONE) begin
				k = 12;
				c = (3 * ONE) >> 2;
			end else if (11 * t < 10 * ONE) begin
				k = 18;
				c = (15 * ONE) >> 4;
			end else begin
				k = 21;
				c = (63 * ONE) >> 6;
			end
			u = longint'(22 * t) - k * longint'(ONE);
			a = (u < 0) ? longint'(-u) : u;
			return ((a * a) >> (F + 6)) + c;
		end
		default: return t;
		endcase
	endfunction

	// advances the tween by one transfer, returns 1 when a result is due
	function automatic bit step_tween(input logic [OP_W-1:0] op, input logic [DELTA_W-1:0] dt,
			output tween_point_t pt);
		longint unsigned span, t;
		longint          val;
		pt = '0;
		case (op)
		OP_TICK: begin
			if (!running || paused || completed)
				return 0;
			elapsed = elapsed + dt;
			if (elapsed > ELAPSED_MAX)
				elapsed = ELAPSED_MAX;
			span = (dur_reg == '0) ? 1 : dur_reg;
			t = (elapsed >= span) ? ONE : (elapsed << F) / span;
			// floor shift of the signed product
			val = start_val + (((end_val - start_val) * longint'(shape(t))) >>> F);
			pt.value = val[VALUE_WIDTH-1:0];
			pt.done = (t >= ONE);
			if (t >= ONE) begin
				completed = 1'b1;
				running = 1'b0;
			end
			return 1;
		end
		OP_START: begin
			running = 1'b1;
			elapsed = 0;
			completed = 1'b0;
			paused = 1'b0;
			pt.value = start_val[VALUE_WIDTH-1:0];
			return 1;
		end
		OP_STOP: running = 1'b0;
		OP_PAUSE: paused = 1'b1;
		OP_RESUME: paused = 1'b0;
		default: ;
		endcase
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_val = 0;
			end_val = 0;
			dur_reg = DUR_RESET;
			curve_reg = CRV_LINEAR;
			elapsed = 0;
			running = 1'b0;
			paused = 1'b0;
			completed = 1'b0;
			due_q.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				REG_START_VALUE: start_val = $signed(cfg_data[VALUE_WIDTH-1:0]);
				REG_END_VALUE: end_val = $signed(cfg_data[VALUE_WIDTH-1:0]);
				REG_DURATION: dur_reg = cfg_data[DUR_W-1:0];
				REG_EASING: curve_reg = cfg_data[CURVE_W-1:0];
				default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (step_tween(s_tuser, s_tdata, fresh)) begin
					due_q.insert(due_q.size(), fresh);
				end
			end
			if (m_tvalid && m_tready) begin
				if (due_q.size() == 0) begin
					$error("result with nothing due: eased_value %0d done_res %0b",
						$signed(m_tdata[VALUE_WIDTH-1:0]), m_tlast);
					fail_count++;
				end else begin
					head = due_q.pop_front();
					if (m_tdata[VALUE_WIDTH-1:0] !== head.value) begin
						$error("eased_value mismatch: expected %0d, actual %0d",
							$signed(head.value), $signed(m_tdata[VALUE_WIDTH-1:0]));
						fail_count++;
					end
					if (m_tlast !== head.done) begin
						$error("done_res mismatch: expected %0b, actual %0b",
							head.done, m_tlast);
						fail_count++;
					end
				end
			end
			pending_count = due_q.size();
		end
	end

endmodule

[verif/testbench.sv]
// top of the eased tween generator testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
	import etg_pkg::*;

	localparam int VW      = VALUE_WIDTH_DEF;
	localparam int TDATA_W = ((VW + 7) / 8) * 8;
	localparam int CFG_W   = (VW > DUR_W) ? VW : DUR_W;

	// settle time after the last due result, enough for a tick still in flight to finish
	localparam int SETTLE_CYCLES  = 3 * EASE_FRAC_BITS_DEF + 30;
	localparam int HOLD_CYCLES    = 500;
	localparam int CYCLE_LIMIT    = 600000;
	localparam int ITEM_TARGET    = 650;
	localparam int SEGMENT_ITEMS  = 30;

	// op and curve codes past the defined ones
	localparam logic [OP_W-1:0]    OP_FIRST_UNUSED  = OP_RESUME + 1'b1;
	localparam logic [OP_W-1:0]    OP_CODE_MAX      = '1;
	localparam logic [CURVE_W-1:0] CRV_FIRST_UNUSED = CRV_BOUNCE + 1'b1;
	localparam logic [CURVE_W-1:0] CRV_CODE_MAX     = '1;

	localparam logic [VW-1:0]      VAL_MIN = {1'b1, {(VW-1){1'b0}}};
	localparam logic [VW-1:0]      VAL_MAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic [DUR_W-1:0]   DUR_MAX = '1;
	localparam logic [DELTA_W-1:0] DT_MAX  = '1;

	logic clk = 1'b0;
	logic arst_n;

	logic                 s_tvalid;
	logic                 s_tready;
	logic [DELTA_W-1:0]   s_tdata;   // [15:0] delta_time
	logic [OP_W-1:0]      s_tuser;   // [2:0] operation

	logic                 m_tvalid;
	logic                 m_tready;
	logic [TDATA_W-1:0]   m_tdata;   // [VW-1:0] eased_value
	logic                 m_tlast;   // done_res

	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	int fail_count, pending_count;

	// idle percentages for the sending and receiving side, changed per phase
	int  tx_idle_pct = 0;
	int  rx_stall_pct = 0;
	bit  pressure_go = 1'b0;
	logic rx_hold;
	int  cycle_count = 0;
	int  item_count = 0;

	// duration of the current setting, used to size tick deltas
	logic [DUR_W-1:0] cur_dur;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	eased_tween_generator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tween_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	// watchdog: a hung block ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("eased_tween_generator regression: fail");
			$finish;
		end
	end

	// long receiver hold-off so the output register fills and s_tready drops
	initial begin
		rx_hold = 1'b0;
		wait (pressure_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// result side: random stalls, none during a stretch with zero stall rate unless the hold-off is on
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// offers one transfer; tvalid stays high into the next call unless a gap is drawn
	task automatic offer(input logic [OP_W-1:0] op, input logic [DELTA_W-1:0] dt);
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= dt;
		do @(posedge clk); while (!s_tready);
		item_count++;
	endtask

	// waits for every due result, then lets a busy block finish a silent transfer
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// writes all four registers on consecutive edges; only called with the block idle
	task automatic program_tween(input logic [VW-1:0] sv, input logic [VW-1:0] ev,
			input logic [DUR_W-1:0] dur, input logic [CURVE_W-1:0] crv);
		logic [CFG_W-1:0] vals[4];
		logic [CFG_IDX_W-1:0] regs[4];
		vals[0] = CFG_W'(sv);
		vals[1] = CFG_W'(ev);
		vals[2] = CFG_W'(dur);
		vals[3] = CFG_W'(crv);
		regs[0] = REG_START_VALUE;
		regs[1] = REG_END_VALUE;
		regs[2] = REG_DURATION;
		regs[3] = REG_EASING;
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cur_dur = dur;
	endtask

	function automatic logic [VW-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return VAL_MIN;
		if (r < 16)
			return VAL_MAX;
		if (r < 21)
			return '0;
		return VW'($urandom_range(0, VAL_MIN + VAL_MAX));
	endfunction

	function automatic logic [DUR_W-1:0] pick_duration();
		int r;
		r = $urandom_range(99);
		if (r < 35)
			return DUR_W'($urandom_range(1, 16));
		if (r < 70)
			return DUR_W'($urandom_range(17, 3000));
		if (r < 85)
			return DUR_W'($urandom_range(3001, 200000));
		if (r < 89)
			return DUR_MAX;
		if (r < 92)
			return DUR_W'($urandom_range(0, DUR_MAX));
		if (r < 96)
			return '0;
		return DUR_W'(1);
	endfunction

	// mostly deltas that finish a tween in a handful of ticks, some full range
	function automatic logic [DELTA_W-1:0] pick_delta();
		longint unsigned span, step_max;
		span = (cur_dur == '0) ? 1 : cur_dur;
		step_max = span / 3 + 1;
		if (step_max > DT_MAX)
			step_max = DT_MAX;
		if ($urandom_range(99) < 85)
			return DELTA_W'($urandom_range(0, 32'(step_max)));
		return DELTA_W'($urandom_range(0, DT_MAX));
	endfunction

	initial begin
		int r, seg;
		logic [CURVE_W-1:0] crv;

		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= OP_TICK;
		cfg_we    <= 1'b0;
		cfg_index <= REG_START_VALUE;
		cfg_data  <= '0;
		cur_dur = DUR_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full-scale sweep with a zero duration, which counts as one
		program_tween(VAL_MIN, VAL_MAX, '0, CRV_LINEAR);
		offer(OP_TICK, '0);        // idle tick gives nothing
		offer(OP_PAUSE, '0);       // pause while idle, cleared by start
		offer(OP_START, DT_MAX);
		offer(OP_TICK, '0);        // t stays zero
		offer(OP_TICK, DT_MAX);    // reaches the end
		offer(OP_TICK, DELTA_W'(1)); // completed, ignored
		for (int c = OP_FIRST_UNUSED; c <= OP_CODE_MAX; c++)
			offer(c[OP_W-1:0], DT_MAX);
		offer(OP_RESUME, '0);
		offer(OP_STOP, '0);
		drain();

		// reversed sweep, longest duration, bounce, pause in the middle
		program_tween(VAL_MAX, VAL_MIN, DUR_MAX, CRV_BOUNCE);
		offer(OP_START, '0);
		offer(OP_TICK, DT_MAX);
		offer(OP_PAUSE, '0);
		offer(OP_TICK, DELTA_W'(1)); // paused, ignored
		offer(OP_RESUME, '0);
		offer(OP_TICK, DELTA_W'(16'h8000));
		offer(OP_STOP, '0);
		offer(OP_TICK, DELTA_W'(5)); // stopped, ignored
		drain();

		// ease-in-out hitting its midpoint exactly, then an unknown curve code
		program_tween('0, VW'(1000), DUR_W'(2), CRV_IN_OUT);
		offer(OP_START, '0);
		offer(OP_TICK, DELTA_W'(1));
		offer(OP_TICK, DELTA_W'(1));
		drain();
		program_tween(VAL_MAX, '0, DUR_W'(3), CRV_CODE_MAX);
		offer(OP_START, '0);
		offer(OP_TICK, DELTA_W'(2));
		drain();

		// random part: one setting and one idle pattern per segment
		seg = 0;
		while (item_count < ITEM_TARGET) begin
			case (seg % 4)
			0: begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end
			1: begin
				tx_idle_pct = 55;
				rx_stall_pct = 0;
			end
			2: begin
				tx_idle_pct = 0;
				rx_stall_pct = 55;
			end
			default: begin
				tx_idle_pct = 32;
				rx_stall_pct = 32;
			end
			endcase
			if (seg == 4) begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
				pressure_go = 1'b1;
			end

			crv = ($urandom_range(99) < 85) ? CURVE_W'($urandom_range(CRV_LINEAR, CRV_BOUNCE))
				: CURVE_W'($urandom_range(CRV_FIRST_UNUSED, CRV_CODE_MAX));
			program_tween(pick_value(), pick_value(), pick_duration(), crv);

			// a well-formed run: start, then mostly ticks with some control noise
			offer(OP_START, pick_delta());
			for (int i = 1; i < SEGMENT_ITEMS; i++) begin
				r = $urandom_range(99);
				if (r < 72)
					offer(OP_TICK, pick_delta());
				else if (r < 82)
					offer(OP_START, pick_delta());
				else if (r < 87)
					offer(OP_PAUSE, pick_delta());
				else if (r < 92)
					offer(OP_RESUME, pick_delta());
				else if (r < 96)
					offer(OP_STOP, pick_delta());
				else
					offer(OP_W'($urandom_range(OP_FIRST_UNUSED, OP_CODE_MAX)), pick_delta());
			end
			drain();
			seg++;
		end

		if (fail_count == 0 && pending_count == 0)
			$display("eased_tween_generator regression: pass");
		else
			$display("eased_tween_generator regression: fail");
		$finish;
	end

endmodule

[sim.f]
hdl/etg_pkg.sv
hdl/etg_div.sv
hdl/etg_mul.sv
hdl/eased_tween_generator.sv
verif/tween_checker.sv
verif/testbench.sv
